[design/array_doubly_linked_list_macros.svh]
`ifndef ARRAY_DOUBLY_LINKED_LIST_MACROS_SVH
`define ARRAY_DOUBLY_LINKED_LIST_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ADLL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define ADLL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/adll_pkg.sv]
package adll_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int NODE_W     = 11;
    localparam int ADDR_W     = $clog2(NODE_COUNT);
    localparam int DATA_W     = 32;
    localparam int FUNC_W     = 3;
    localparam int STAT_W     = 2;
    localparam int IN_W       = 48;
    localparam int OUT_W      = 80;

    localparam logic [FUNC_W-1:0] FN_PUSH_L = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_R = 3'd1;
    localparam logic [FUNC_W-1:0] FN_DELETE = 3'd2;
    localparam logic [FUNC_W-1:0] FN_INS_L  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_INS_R  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_READ   = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

    typedef enum logic [2:0] {
        ACT_FETCH,
        ACT_CHECK,
        ACT_NEW,
        ACT_LINK,
        ACT_UNLINK,
        ACT_EMIT
    } act_t;

    typedef enum logic [1:0] {
        J_GO,
        J_WAIT_IN,
        J_DISPATCH,
        J_WAIT_OUT
    } jmp_t;

    typedef enum logic [1:0] {
        CLS_DONE,
        CLS_INSERT,
        CLS_DELETE
    } cls_t;

    typedef enum logic [2:0] {
        UC_FETCH,
        UC_CHECK,
        UC_NEW,
        UC_LINK,
        UC_UNLINK,
        UC_EMIT
    } step_t;

    typedef struct packed {
        act_t  act;
        jmp_t  jmp;
        step_t target;
    } ctrl_t;

    // microprogram
    function automatic ctrl_t uc_rom(input step_t step_pos);
        ctrl_t word;
        unique case (step_pos)
            UC_FETCH:  word = '{act: ACT_FETCH,  jmp: J_WAIT_IN,  target: UC_CHECK};
            UC_CHECK:  word = '{act: ACT_CHECK,  jmp: J_DISPATCH, target: UC_NEW};
            UC_NEW:    word = '{act: ACT_NEW,    jmp: J_GO,       target: UC_LINK};
            UC_LINK:   word = '{act: ACT_LINK,   jmp: J_GO,       target: UC_EMIT};
            UC_UNLINK: word = '{act: ACT_UNLINK, jmp: J_GO,       target: UC_EMIT};
            UC_EMIT:   word = '{act: ACT_EMIT,   jmp: J_WAIT_OUT, target: UC_FETCH};
            default:   word = '{act: ACT_FETCH,  jmp: J_WAIT_IN,  target: UC_CHECK};
        endcase
        return word;
    endfunction

endpackage

[design/array_doubly_linked_list.sv]
// channel  dir  tdata fields (low bit up)
// s_axis   in   func[2:0] node_number[13:3] data_value[45:14] zero[47:46]
// m_axis   out  status[1:0] left_end[12:2] right_end[23:13] read_value[55:24]
//               read_left[66:56] read_right[77:67] zero[79:78]
//
// one word at a time, in microprogram steps around the single-port link memories;
// insert: fetch check new link emit; delete: fetch check unlink emit; read or rejected: fetch check emit
// the next word is taken while the previous result waits in the output register
// reset clears the ends, the node count, the output valid and the sequencer; node memories need no clear
// a stalled output holds the sequencer in its emit step
`include "array_doubly_linked_list_macros.svh"

module array_doubly_linked_list (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [adll_pkg::IN_W-1:0]  s_axis_tdata,  // func, node_number, data_value
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [adll_pkg::OUT_W-1:0] m_axis_tdata   // status, left_end, right_end,
                                                      // read_value, read_left, read_right
);
    import adll_pkg::*;

    ctrl_t ctrl;
    cls_t  cls;
    logic  in_accept;
    logic  out_free;

    logic [NODE_W-1:0] in_node;
    logic [ADDR_W-1:0] rd_addr;

    logic [FUNC_W-1:0] func_reg;
    logic [NODE_W-1:0] k_reg;
    logic [DATA_W-1:0] x_reg;
    logic [NODE_W-1:0] used_reg;
    logic [NODE_W-1:0] left_end_reg;
    logic [NODE_W-1:0] right_end_reg;
    logic [NODE_W-1:0] lft_reg;
    logic [NODE_W-1:0] rgt_reg;
    logic [NODE_W-1:0] n_reg;
    logic [STAT_W-1:0] status_reg;
    logic [DATA_W-1:0] rv_reg;
    logic [NODE_W-1:0] rl_reg;
    logic [NODE_W-1:0] rr_reg;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;

    logic [DATA_W-1:0] value_rd_reg;
    logic [NODE_W-1:0] left_rd_reg;
    logic [NODE_W-1:0] right_rd_reg;
    logic              live_rd_reg;

    logic [DATA_W-1:0] value_mem [NODE_COUNT];
    logic [NODE_W-1:0] left_mem  [NODE_COUNT];
    logic [NODE_W-1:0] right_mem [NODE_COUNT];
    logic              live_mem  [NODE_COUNT];

    logic              node_ok;
    logic              full;
    logic              read_hit;
    logic [STAT_W-1:0] chk_status;
    logic [NODE_W-1:0] chk_lft;
    logic [NODE_W-1:0] chk_rgt;

    logic              relink;
    logic [ADDR_W-1:0] new_addr;
    logic              value_we;
    logic              live_we;
    logic [ADDR_W-1:0] live_wa;
    logic              left_we;
    logic [ADDR_W-1:0] left_wa;
    logic [NODE_W-1:0] left_wd;
    logic              right_we;
    logic [ADDR_W-1:0] right_wa;
    logic [NODE_W-1:0] right_wd;

    adll_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .out_free (out_free),
        .cls      (cls),
        .ctrl     (ctrl)
    );

    assign s_axis_tready = (ctrl.act == ACT_FETCH);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign in_node       = s_axis_tdata[13:3];
    assign rd_addr       = ADDR_W'(in_node - NODE_W'(1));

    // reference check and dispatch class
    always_comb
    begin
        node_ok    = (k_reg != '0) && (k_reg <= used_reg) && live_rd_reg;
        full       = (used_reg == NODE_W'(NODE_COUNT));
        read_hit   = 1'b0;
        chk_status = ST_OK;
        cls        = CLS_DONE;
        chk_lft    = '0;
        chk_rgt    = '0;
        unique case (func_reg)
            FN_PUSH_L:
            begin
                if (full)
                begin
                    chk_status = ST_FULL;
                end
                else
                begin
                    cls     = CLS_INSERT;
                    chk_rgt = left_end_reg;
                end
            end
            FN_PUSH_R:
            begin
                if (full)
                begin
                    chk_status = ST_FULL;
                end
                else
                begin
                    cls     = CLS_INSERT;
                    chk_lft = right_end_reg;
                end
            end
            FN_DELETE:
            begin
                if (!node_ok)
                begin
                    chk_status = ST_BAD;
                end
                else
                begin
                    cls     = CLS_DELETE;
                    chk_lft = left_rd_reg;
                    chk_rgt = right_rd_reg;
                end
            end
            FN_INS_L:
            begin
                if (!node_ok)
                begin
                    chk_status = ST_BAD;
                end
                else if (full)
                begin
                    chk_status = ST_FULL;
                end
                else
                begin
                    cls     = CLS_INSERT;
                    chk_lft = left_rd_reg;
                    chk_rgt = k_reg;
                end
            end
            FN_INS_R:
            begin
                if (!node_ok)
                begin
                    chk_status = ST_BAD;
                end
                else if (full)
                begin
                    chk_status = ST_FULL;
                end
                else
                begin
                    cls     = CLS_INSERT;
                    chk_lft = k_reg;
                    chk_rgt = right_rd_reg;
                end
            end
            FN_READ:
            begin
                if (!node_ok)
                begin
                    chk_status = ST_BAD;
                end
                else
                begin
                    read_hit = 1'b1;
                end
            end
            default:
            begin
                chk_status = ST_OK;
            end
        endcase
    end

    // memory write ports
    always_comb
    begin
        relink   = (ctrl.act == ACT_LINK) || (ctrl.act == ACT_UNLINK);
        new_addr = ADDR_W'(n_reg - NODE_W'(1));
        value_we = (ctrl.act == ACT_NEW);
        live_we  = (ctrl.act == ACT_NEW) || (ctrl.act == ACT_UNLINK);
        live_wa  = (ctrl.act == ACT_NEW) ? new_addr : ADDR_W'(k_reg - NODE_W'(1));
        left_we  = (ctrl.act == ACT_NEW) || (relink && (rgt_reg != '0));
        right_we = (ctrl.act == ACT_NEW) || (relink && (lft_reg != '0));
        if (ctrl.act == ACT_NEW)
        begin
            left_wa  = new_addr;
            left_wd  = lft_reg;
            right_wa = new_addr;
            right_wd = rgt_reg;
        end
        else
        begin
            left_wa  = ADDR_W'(rgt_reg - NODE_W'(1));
            left_wd  = (ctrl.act == ACT_UNLINK) ? lft_reg : n_reg;
            right_wa = ADDR_W'(lft_reg - NODE_W'(1));
            right_wd = (ctrl.act == ACT_UNLINK) ? rgt_reg : n_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (value_we)
        begin
            value_mem[new_addr] <= x_reg;
        end
        if (in_accept)
        begin
            value_rd_reg <= value_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (live_we)
        begin
            live_mem[live_wa] <= (ctrl.act == ACT_NEW);
        end
        if (in_accept)
        begin
            live_rd_reg <= live_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (left_we)
        begin
            left_mem[left_wa] <= left_wd;
        end
        if (in_accept)
        begin
            left_rd_reg <= left_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (right_we)
        begin
            right_mem[right_wa] <= right_wd;
        end
        if (in_accept)
        begin
            right_rd_reg <= right_mem[rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg <= s_axis_tdata[2:0];
            k_reg    <= in_node;
            x_reg    <= s_axis_tdata[45:14];
        end
        if (ctrl.act == ACT_CHECK)
        begin
            status_reg <= chk_status;
            lft_reg    <= chk_lft;
            rgt_reg    <= chk_rgt;
            n_reg      <= used_reg + NODE_W'(1);
            rv_reg     <= read_hit ? value_rd_reg : '0;
            rl_reg     <= read_hit ? left_rd_reg : '0;
            rr_reg     <= read_hit ? right_rd_reg : '0;
        end
        if ((ctrl.act == ACT_EMIT) && out_free)
        begin
            out_data_reg <= {2'b00, rr_reg, rl_reg, rv_reg,
                             right_end_reg, left_end_reg, status_reg};
        end
    end

    // list ends, node count, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            left_end_reg  <= '0;
            right_end_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.act == ACT_LINK)
            begin
                used_reg <= n_reg;
                if (lft_reg == '0)
                begin
                    left_end_reg <= n_reg;
                end
                if (rgt_reg == '0)
                begin
                    right_end_reg <= n_reg;
                end
            end
            else if (ctrl.act == ACT_UNLINK)
            begin
                if (lft_reg == '0)
                begin
                    left_end_reg <= rgt_reg;
                end
                if (rgt_reg == '0)
                begin
                    right_end_reg <= lft_reg;
                end
            end
            if ((ctrl.act == ACT_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `ADLL_ASSERT_IMP(a_ends_agree, 1'b1, (left_end_reg == '0) == (right_end_reg == '0), "list ends disagree on empty")
    `ADLL_ASSERT_NXT(a_link_ends, ctrl.act == ACT_LINK, (left_end_reg != '0) && (right_end_reg != '0), "list empty after insert")
    `ADLL_ASSERT_NXT(a_used_step, 1'b1, (used_reg == $past(used_reg)) || (used_reg == $past(used_reg) + NODE_W'(1)), "node count jumped")

endmodule

[design/adll_seq.sv]
module adll_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            out_free,
    input  adll_pkg::cls_t  cls,
    output adll_pkg::ctrl_t ctrl
);
    import adll_pkg::*;

    step_t step_reg;
    step_t step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= UC_FETCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_comb
    begin
        ctrl = uc_rom(step_reg);
        unique case (ctrl.jmp)
            J_GO:       step_next = ctrl.target;
            J_WAIT_IN:  step_next = in_valid ? ctrl.target : step_reg;
            J_WAIT_OUT: step_next = out_free ? ctrl.target : step_reg;
            J_DISPATCH:
            begin
                unique case (cls)
                    CLS_INSERT: step_next = ctrl.target;
                    CLS_DELETE: step_next = UC_UNLINK;
                    default:    step_next = UC_EMIT;
                endcase
            end
            default:    step_next = UC_FETCH;
        endcase
    end

endmodule

[test/array_doubly_linked_list_test.sv]
module array_doubly_linked_list_test;
    timeunit 1ns;
    timeprecision 1ps;

    import adll_pkg::*;

    localparam logic [FUNC_W-1:0] FN_UNUSED_A = 3'd6;
    localparam logic [FUNC_W-1:0] FN_UNUSED_B = 3'd7;
    localparam int RANDOM_OPS   = 1250;
    localparam int AFTER_FULL   = 100;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [NODE_W-1:0] left_end;
        logic [NODE_W-1:0] right_end;
        logic [DATA_W-1:0] read_value;
        logic [NODE_W-1:0] read_left;
        logic [NODE_W-1:0] read_right;
    } list_reply_t;

    class list_checker;
        logic [DATA_W-1:0] value_mem [NODE_COUNT+1];
        logic [NODE_W-1:0] left_of [NODE_COUNT+1];
        logic [NODE_W-1:0] right_of [NODE_COUNT+1];
        bit                live [NODE_COUNT+1];
        logic [NODE_W-1:0] head;
        logic [NODE_W-1:0] tail;
        int                used;
        int                errors;
        list_reply_t       expected_replies [$];

        function new();
            head = '0;
            tail = '0;
            used = 0;
            errors = 0;
            foreach (live[i])
                live[i] = 1'b0;
        endfunction

        function bit node_ok(int k);
            if (k < 1 || k > used)
                return 1'b0;
            return live[k];
        endfunction

        // new node between l and r, either may be 0 for an end
        function void splice_new(logic [DATA_W-1:0] v, logic [NODE_W-1:0] l,
                                 logic [NODE_W-1:0] r);
            logic [NODE_W-1:0] n;
            n = NODE_W'(used + 1);
            value_mem[n] = v;
            left_of[n] = l;
            right_of[n] = r;
            live[n] = 1'b1;
            used = used + 1;
            if (l != 0)
                right_of[l] = n;
            else
                head = n;
            if (r != 0)
                left_of[r] = n;
            else
                tail = n;
        endfunction

        function void note_word(logic [IN_W-1:0] w);
            logic [FUNC_W-1:0] f;
            logic [NODE_W-1:0] k;
            logic [DATA_W-1:0] v;
            logic [NODE_W-1:0] l;
            logic [NODE_W-1:0] r;
            list_reply_t       e;
            bit                full;
            f = w[2:0];
            k = w[13:3];
            v = w[45:14];
            e.status = ST_OK;
            e.read_value = '0;
            e.read_left = '0;
            e.read_right = '0;
            full = used >= NODE_COUNT;
            case (f)
                FN_PUSH_L:
                    if (full)
                        e.status = ST_FULL;
                    else
                        splice_new(v, '0, head);
                FN_PUSH_R:
                    if (full)
                        e.status = ST_FULL;
                    else
                        splice_new(v, tail, '0);
                FN_DELETE:
                    if (!node_ok(int'(k)))
                        e.status = ST_BAD;
                    else
                    begin
                        l = left_of[k];
                        r = right_of[k];
                        if (l != 0)
                            right_of[l] = r;
                        else
                            head = r;
                        if (r != 0)
                            left_of[r] = l;
                        else
                            tail = l;
                        live[k] = 1'b0;
                    end
                FN_INS_L:
                    if (!node_ok(int'(k)))
                        e.status = ST_BAD;
                    else if (full)
                        e.status = ST_FULL;
                    else
                        splice_new(v, left_of[k], k);
                FN_INS_R:
                    if (!node_ok(int'(k)))
                        e.status = ST_BAD;
                    else if (full)
                        e.status = ST_FULL;
                    else
                        splice_new(v, k, right_of[k]);
                FN_READ:
                    if (!node_ok(int'(k)))
                        e.status = ST_BAD;
                    else
                    begin
                        e.read_value = value_mem[k];
                        e.read_left = left_of[k];
                        e.read_right = right_of[k];
                    end
                default:
                    ;
            endcase
            e.left_end = head;
            e.right_end = tail;
            expected_replies.push_back(e);
        endfunction

        function void check_reply(logic [OUT_W-1:0] t);
            list_reply_t e;
            list_reply_t got;
            got.status = t[1:0];
            got.left_end = t[12:2];
            got.right_end = t[23:13];
            got.read_value = t[55:24];
            got.read_left = t[66:56];
            got.read_right = t[77:67];
            if (expected_replies.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word on m_axis: %h", t);
                return;
            end
            e = expected_replies.pop_front();
            if (got.status !== e.status || got.left_end !== e.left_end ||
                got.right_end !== e.right_end || got.read_value !== e.read_value ||
                got.read_left !== e.read_left || got.read_right !== e.read_right)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $write("mismatch: expected st=%0d ends=%0d/%0d val=%h nb=%0d/%0d, ",
                           e.status, e.left_end, e.right_end, e.read_value,
                           e.read_left, e.read_right);
                    $display("got st=%0d ends=%0d/%0d val=%h nb=%0d/%0d",
                             got.status, got.left_end, got.right_end, got.read_value,
                             got.read_left, got.read_right);
                end
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    list_checker sb = new();
    bit          calm = 1'b0;
    int          stall_cycles = 0;

    array_doubly_linked_list dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        m_axis_tready <= calm || ($urandom_range(99) >= 35);

    always @(posedge clk)
        if (m_axis_tvalid && m_axis_tready)
            sb.check_reply(m_axis_tdata);

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic drive_op(input logic [FUNC_W-1:0] f, input logic [NODE_W-1:0] k,
                            input logic [DATA_W-1:0] v);
        while (!calm && $urandom_range(99) < 35)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, v, k, f};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_word(s_axis_tdata);
    endtask

    task automatic random_ops();
        int               i;
        int               past_full;
        int               roll;
        bit               filling;
        logic [FUNC_W-1:0] f;
        int               k;
        i = 0;
        past_full = 0;
        while (i < RANDOM_OPS || past_full < AFTER_FULL)
        begin
            calm = (i >= 500 && i < 700);
            filling = sb.used < NODE_COUNT;
            if (!filling)
                past_full++;
            k = 0;
            if (sb.used > 0)
                for (int t = 0; t < 8; t++)
                begin
                    k = $urandom_range(sb.used, 1);
                    if (sb.live[k])
                        break;
                end
            roll = $urandom_range(99);
            if (roll < 4)
            begin
                // spare codes and references to arbitrary numbers
                if ($urandom_range(1))
                    f = $urandom_range(1) ? FN_UNUSED_A : FN_UNUSED_B;
                else
                    f = FUNC_W'($urandom_range(5, 0));
                k = $urandom_range(2047, 0);
            end
            else if (roll < (filling ? 90 : 30))
            begin
                case ($urandom_range(3))
                    0: f = FN_PUSH_L;
                    1: f = FN_PUSH_R;
                    2: f = FN_INS_L;
                    default: f = FN_INS_R;
                endcase
            end
            else if (roll < (filling ? 96 : 70))
                f = FN_READ;
            else
                f = FN_DELETE;
            drive_op(f, NODE_W'(k), $urandom);
            i++;
        end
        calm = 1'b0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list and bad references, then pushes and inserts in the middle
        drive_op(FN_READ, 1, 32'h0);
        drive_op(FN_DELETE, 0, 32'h0);
        drive_op(FN_PUSH_L, 0, 32'h8000_0000);
        drive_op(FN_PUSH_R, 0, 32'h7fff_ffff);
        drive_op(FN_INS_L, 2, 32'h0000_0000);
        drive_op(FN_INS_R, 1, 32'hffff_ffff);
        drive_op(FN_READ, 4, 32'h0);
        drive_op(FN_READ, 1, 32'h0);
        drive_op(FN_READ, 2, 32'h0);
        // inserts at both ends
        drive_op(FN_INS_R, 2, 32'h1234_5678);
        drive_op(FN_INS_L, 1, 32'ha5a5_a5a5);
        // middle, head and tail deletes
        drive_op(FN_DELETE, 3, 32'h0);
        drive_op(FN_READ, 3, 32'h0);
        drive_op(FN_DELETE, 6, 32'h0);
        drive_op(FN_DELETE, 5, 32'h0);
        drive_op(FN_INS_L, 3, 32'h0bad_0bad);
        drive_op(FN_READ, 2047, 32'h0);
        drive_op(FN_DELETE, 1024, 32'h0);
        drive_op(FN_UNUSED_A, 1365, 32'h5555_aaaa);
        drive_op(FN_UNUSED_B, 682, 32'haaaa_5555);
        drive_op(FN_READ, 7, 32'h0);
        // back to empty, then push onto the empty list from each side
        drive_op(FN_DELETE, 1, 32'h0);
        drive_op(FN_DELETE, 4, 32'h0);
        drive_op(FN_DELETE, 2, 32'h0);
        drive_op(FN_PUSH_R, 0, 32'h0000_0001);
        drive_op(FN_DELETE, 7, 32'h0);
        drive_op(FN_PUSH_L, 0, 32'hffff_fffe);

        random_ops();
        s_axis_tvalid <= 1'b0;

        while (sb.expected_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.expected_replies.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
